FILE: rtl/core/mid_pkg.sv
// Types, constants and helper functions shared by the motion impact detector.
package mid_pkg;

    // Operation codes carried in the op field of a sample transaction.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Impact kinds.
    localparam logic KIND_STAB     = 1'b0;
    localparam logic KIND_ROTATION = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLASS_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN    = 3'd4;
    localparam int CFG_DATA_W = 32;

    // Configuration reset values.
    localparam logic [15:0] RST_ACCEL_LIMIT = 16'd3000;
    localparam logic [15:0] RST_AXIS_LIMIT  = 16'd2500;
    localparam logic [15:0] RST_DROP_LIMIT  = 16'd300;
    localparam logic [15:0] RST_CLASS_LIMIT = 16'd500;
    localparam logic [31:0] RST_COOLDOWN    = 32'd500;

    // Square root unit: first trial bit and index of the last step of each root.
    localparam logic [31:0] ROOT_FIRST_BIT = 32'h4000_0000;
    localparam logic [3:0]  ROOT_LAST_STEP = 4'd15;

    // Squaring pass: six axes plus a final step to drain the product register.
    localparam logic [3:0]  SQ_LAST_STEP = 4'd6;
    localparam int          AXIS_COUNT   = 6;

    // Input transaction payload.
    typedef struct packed {
        logic               op;
        logic [31:0]        time_ms;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } sample_t;

    // Output transaction payload.
    typedef struct packed {
        logic        impact_now;
        logic        impact_kind;
        logic        flag_value;
        logic [31:0] stab_total;
        logic [31:0] rotation_total;
        logic [15:0] accel_magnitude;
        logic [15:0] peak_axis;
        logic [15:0] rate_magnitude;
        logic [15:0] rate_drop;
    } result_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_FINISH
    } state_t;

    // Absolute value of a signed 16-bit axis; the most negative code gives 32768.
    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        logic [15:0] neg;
        neg = 16'(~v) + 16'd1;
        return v[15] ? neg : 16'(v);
    endfunction

endpackage

FILE: rtl/core/motion_impact_detector.sv
// Motion impact detector: iterative magnitude, drop and trigger logic around one shared datapath.
// A sample passes through the shared 16x16 squaring multiplier, the digit-by-digit square root
// unit (run once for each magnitude) and a finishing state that waits for the output register.
// A query goes straight to the finishing state. One transaction is in work at a time, so a new
// transaction is taken only after the last one has loaded its result.
// Reset (rst_n low, asynchronous) restores the default limits and clears counters and flags.
module motion_impact_detector
    import mid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  sample_t                sample,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result
);

    // Configuration registers.
    logic [15:0] accel_limit_reg;
    logic [15:0] axis_limit_reg;
    logic [15:0] drop_limit_reg;
    logic [15:0] class_limit_reg;
    logic [31:0] cooldown_reg;

    // Detector state.
    logic [15:0] prev_rmag_reg;
    logic        first_pending_reg;
    logic [31:0] last_time_reg;
    logic        sticky_reg;
    logic [31:0] stab_cnt_reg;
    logic [31:0] rot_cnt_reg;
    logic        last_kind_reg;

    // Sequencer and datapath registers.
    state_t      state_reg;
    state_t      state_next;
    sample_t     item_reg;
    logic [3:0]  step_reg;
    logic [31:0] prod_reg;
    logic [31:0] acc_a_reg;
    logic [31:0] acc_r_reg;
    logic [31:0] rem_reg;
    logic [31:0] root_reg;
    logic [31:0] bit_reg;
    logic        root_sel_reg;
    logic [15:0] amag_reg;
    logic [15:0] rmag_reg;

    // Output register.
    logic        out_valid_reg;
    result_t     out_reg;

    logic        accept;
    logic        out_free;
    logic [15:0] sq_operand;
    logic [31:0] trial;
    logic        trial_ge;
    logic [31:0] rem_next;
    logic [31:0] root_next;
    logic [15:0] abs_ax;
    logic [15:0] abs_ay;
    logic [15:0] abs_az;
    logic [15:0] peak;
    logic [15:0] drop;
    logic [31:0] elapsed;
    logic        seen;
    logic        fire;

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Configuration write port; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_limit_reg <= RST_ACCEL_LIMIT;
            axis_limit_reg  <= RST_AXIS_LIMIT;
            drop_limit_reg  <= RST_DROP_LIMIT;
            class_limit_reg <= RST_CLASS_LIMIT;
            cooldown_reg    <= RST_COOLDOWN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ACCEL_LIMIT: accel_limit_reg <= cfg_data[15:0];
                CFG_AXIS_LIMIT:  axis_limit_reg  <= cfg_data[15:0];
                CFG_DROP_LIMIT:  drop_limit_reg  <= cfg_data[15:0];
                CFG_CLASS_LIMIT: class_limit_reg <= cfg_data[15:0];
                CFG_COOLDOWN:    cooldown_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Operand of the shared multiplier, one axis per squaring step.
    always_comb
    begin
        case (step_reg)
            4'd0:    sq_operand = abs16(item_reg.accel_x);
            4'd1:    sq_operand = abs16(item_reg.accel_y);
            4'd2:    sq_operand = abs16(item_reg.accel_z);
            4'd3:    sq_operand = abs16(item_reg.rate_x);
            4'd4:    sq_operand = abs16(item_reg.rate_y);
            4'd5:    sq_operand = abs16(item_reg.rate_z);
            default: sq_operand = 16'd0;
        endcase
    end

    // One step of the digit-by-digit square root.
    always_comb
    begin
        trial     = root_reg + bit_reg;
        trial_ge  = (rem_reg >= trial);
        rem_next  = trial_ge ? (rem_reg - trial) : rem_reg;
        root_next = trial_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    end

    // Peak axis, rotation drop and the trigger decision for the finishing state.
    always_comb
    begin
        abs_ax = abs16(item_reg.accel_x);
        abs_ay = abs16(item_reg.accel_y);
        abs_az = abs16(item_reg.accel_z);
        peak   = abs_ax;
        if (abs_ay > peak)
        begin
            peak = abs_ay;
        end
        if (abs_az > peak)
        begin
            peak = abs_az;
        end
        if (!first_pending_reg && (prev_rmag_reg > rmag_reg))
        begin
            drop = prev_rmag_reg - rmag_reg;
        end
        else
        begin
            drop = 16'd0;
        end
        elapsed = item_reg.time_ms - last_time_reg;
        seen    = (amag_reg > accel_limit_reg) || (peak > axis_limit_reg) ||
                  (drop > drop_limit_reg);
        fire    = seen && (elapsed > cooldown_reg);
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (sample.op == OP_QUERY) ? ST_FINISH : ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (step_reg == SQ_LAST_STEP)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (step_reg == ROOT_LAST_STEP && root_sel_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath: squaring, accumulation and the two roots.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_reg  <= sample;
                    step_reg  <= 4'd0;
                    acc_a_reg <= 32'd0;
                    acc_r_reg <= 32'd0;
                end
            end
            ST_SQUARE:
            begin
                prod_reg <= 32'(sq_operand) * 32'(sq_operand);
                if (step_reg >= 4'd1 && step_reg <= 4'd3)
                begin
                    acc_a_reg <= acc_a_reg + prod_reg;
                end
                else if (step_reg >= 4'd4)
                begin
                    acc_r_reg <= acc_r_reg + prod_reg;
                end
                if (step_reg == SQ_LAST_STEP)
                begin
                    step_reg     <= 4'd0;
                    rem_reg      <= acc_a_reg;
                    root_reg     <= 32'd0;
                    bit_reg      <= ROOT_FIRST_BIT;
                    root_sel_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 4'd1;
                end
            end
            ST_ROOT:
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == ROOT_LAST_STEP)
                begin
                    if (!root_sel_reg)
                    begin
                        amag_reg     <= root_next[15:0];
                        rem_reg      <= acc_r_reg;
                        root_reg     <= 32'd0;
                        bit_reg      <= ROOT_FIRST_BIT;
                        root_sel_reg <= 1'b1;
                    end
                    else
                    begin
                        rmag_reg <= root_next[15:0];
                    end
                end
                else
                begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                end
            end
            default: ;
        endcase
    end

    // Detector state update and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_rmag_reg     <= 16'd0;
            first_pending_reg <= 1'b1;
            last_time_reg     <= 32'd0;
            sticky_reg        <= 1'b0;
            stab_cnt_reg      <= 32'd0;
            rot_cnt_reg       <= 32'd0;
            last_kind_reg     <= KIND_STAB;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (item_reg.op == OP_QUERY)
                begin
                    sticky_reg <= 1'b0;
                end
                else
                begin
                    first_pending_reg <= 1'b0;
                    prev_rmag_reg     <= rmag_reg;
                    if (fire)
                    begin
                        if (rmag_reg >= class_limit_reg)
                        begin
                            rot_cnt_reg   <= rot_cnt_reg + 32'd1;
                            last_kind_reg <= KIND_ROTATION;
                        end
                        else
                        begin
                            stab_cnt_reg  <= stab_cnt_reg + 32'd1;
                            last_kind_reg <= KIND_STAB;
                        end
                        sticky_reg    <= 1'b1;
                        last_time_reg <= item_reg.time_ms;
                    end
                end
            end
        end
    end

    // Output payload register, loaded when the transaction finishes.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
        begin
            if (item_reg.op == OP_QUERY)
            begin
                out_reg.impact_now      <= 1'b0;
                out_reg.impact_kind     <= last_kind_reg;
                out_reg.flag_value      <= sticky_reg;
                out_reg.stab_total      <= stab_cnt_reg;
                out_reg.rotation_total  <= rot_cnt_reg;
                out_reg.accel_magnitude <= 16'd0;
                out_reg.peak_axis       <= 16'd0;
                out_reg.rate_magnitude  <= 16'd0;
                out_reg.rate_drop       <= 16'd0;
            end
            else
            begin
                out_reg.impact_now      <= fire;
                out_reg.flag_value      <= fire ? 1'b1 : sticky_reg;
                out_reg.accel_magnitude <= amag_reg;
                out_reg.peak_axis       <= peak;
                out_reg.rate_magnitude  <= rmag_reg;
                out_reg.rate_drop       <= drop;
                if (fire && rmag_reg >= class_limit_reg)
                begin
                    out_reg.impact_kind    <= KIND_ROTATION;
                    out_reg.stab_total     <= stab_cnt_reg;
                    out_reg.rotation_total <= rot_cnt_reg + 32'd1;
                end
                else if (fire)
                begin
                    out_reg.impact_kind    <= KIND_STAB;
                    out_reg.stab_total     <= stab_cnt_reg + 32'd1;
                    out_reg.rotation_total <= rot_cnt_reg;
                end
                else
                begin
                    out_reg.impact_kind    <= last_kind_reg;
                    out_reg.stab_total     <= stab_cnt_reg;
                    out_reg.rotation_total <= rot_cnt_reg;
                end
            end
        end
    end

    // An impact always leaves the sticky flag set in the same result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.impact_now) |-> result.flag_value)
    else $error("impact reported without sticky flag");

    // The reported kind of a pending result matches the stored last kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.impact_kind == last_kind_reg))
    else $error("result kind disagrees with stored last kind");

    // Once a transaction is accepted the block stops taking new ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
    else $error("second transaction accepted while one is in work");

    // The root unit only runs after a squaring pass has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(state_reg == ST_ROOT)) |-> ($past(state_reg) == ST_SQUARE))
    else $error("root unit started without a squaring pass");

endmodule

FILE: dv/motion_impact_detector_tb.sv
// Self-checking testbench for the motion impact detector with a built-in behavioral predictor.
module motion_impact_detector_tb
    import mid_pkg::*;
();

    // Clock, reset and block ports; the driven inputs are known from time zero.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   sample_valid = 1'b0;
    logic                   sample_ready;
    sample_t                sample = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;

    motion_impact_detector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Predictor copy of the limit registers.
    logic [15:0] accel_limit = RST_ACCEL_LIMIT;
    logic [15:0] axis_limit  = RST_AXIS_LIMIT;
    logic [15:0] drop_limit  = RST_DROP_LIMIT;
    logic [15:0] class_limit = RST_CLASS_LIMIT;
    logic [31:0] cooldown    = RST_COOLDOWN;

    // Predictor copy of the detector state.
    logic [15:0] prev_rate_mag = '0;
    logic        first_pending = 1'b1;
    logic [31:0] last_hit_time = '0;
    logic        hit_flag      = 1'b0;
    logic [31:0] stab_count    = '0;
    logic [31:0] rot_count     = '0;
    logic        last_kind_q   = KIND_STAB;

    // Queues between stimulus, driver and checker.
    sample_t pending_items[$];
    result_t expected_results[$];

    int fail_count    = 0;
    int items_taken   = 0;
    int results_taken = 0;
    bit calm          = 1'b0;

    // Driver and receiver bookkeeping.
    bit      holding   = 1'b0;
    int      drv_seen  = 0;
    int      drv_gap   = 0;
    sample_t drv_item  = '0;
    int      rcv_seen  = 0;
    int      rcv_stall = 0;

    // Free-running sample timestamp used by the random stimulus.
    logic [31:0] clock_ms = '0;

    // Clock with a period of 10 time units.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Absolute value of one signed axis; the most negative code maps to 32768.
    function automatic logic [15:0] axis_size(input logic signed [15:0] v);
        int iv;
        iv = v;
        return 16'(iv < 0 ? -iv : iv);
    endfunction

    // Floor square root by trying each result bit from the top down.
    function automatic logic [15:0] floor_sqrt(input logic [31:0] n);
        logic [15:0] r;
        logic [15:0] trial;
        r = '0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = r | (16'd1 << b);
            if (64'(trial) * 64'(trial) <= 64'(n))
                r = trial;
        end
        return r;
    endfunction

    function automatic logic [15:0] vector_length(input logic [15:0] a, b, c);
        logic [31:0] sum;
        sum = 32'(a) * 32'(a) + 32'(b) * 32'(b) + 32'(c) * 32'(c);
        return floor_sqrt(sum);
    endfunction

    // Expected result of one accepted transaction; advances the predictor state.
    function automatic result_t impact_outcome(input sample_t s);
        result_t     r;
        logic [15:0] ax, ay, az;
        logic [31:0] elapsed;
        logic        seen;
        r = '0;
        if (s.op == OP_QUERY)
        begin
            r.flag_value = hit_flag;
            hit_flag = 1'b0;
        end
        else
        begin
            ax = axis_size(s.accel_x);
            ay = axis_size(s.accel_y);
            az = axis_size(s.accel_z);
            r.accel_magnitude = vector_length(ax, ay, az);
            r.rate_magnitude = vector_length(axis_size(s.rate_x), axis_size(s.rate_y),
                                             axis_size(s.rate_z));
            r.peak_axis = ax;
            if (ay > r.peak_axis)
                r.peak_axis = ay;
            if (az > r.peak_axis)
                r.peak_axis = az;

            // The drop is zero on the first sample and whenever rotation did not fall.
            if (first_pending)
                first_pending = 1'b0;
            else if (prev_rate_mag > r.rate_magnitude)
                r.rate_drop = prev_rate_mag - r.rate_magnitude;
            prev_rate_mag = r.rate_magnitude;

            seen = (r.accel_magnitude > accel_limit) || (r.peak_axis > axis_limit) ||
                   (r.rate_drop > drop_limit);
            elapsed = s.time_ms - last_hit_time;
            if (seen && elapsed > cooldown)
            begin
                if (r.rate_magnitude >= class_limit)
                begin
                    rot_count++;
                    last_kind_q = KIND_ROTATION;
                end
                else
                begin
                    stab_count++;
                    last_kind_q = KIND_STAB;
                end
                hit_flag = 1'b1;
                last_hit_time = s.time_ms;
                r.impact_now = 1'b1;
            end
            r.flag_value = hit_flag;
        end
        r.impact_kind = last_kind_q;
        r.stab_total = stab_count;
        r.rotation_total = rot_count;
        return r;
    endfunction

    // Mirror a register write into the predictor; unused indexes change nothing.
    task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ACCEL_LIMIT: accel_limit = data[15:0];
            CFG_AXIS_LIMIT:  axis_limit  = data[15:0];
            CFG_DROP_LIMIT:  drop_limit  = data[15:0];
            CFG_CLASS_LIMIT: class_limit = data[15:0];
            CFG_COOLDOWN:    cooldown    = data;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: mirror register writes, predict on each accepted input transaction,
    // and check each accepted result transaction against the oldest expectation.
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (cfg_write)
                apply_register(cfg_index, cfg_data);
            if (sample_valid && sample_ready)
            begin
                expected_results.push_back(impact_outcome(sample));
                items_taken++;
            end
            if (result_valid && result_ready)
            begin
                results_taken++;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("impact_now", want.impact_now, result.impact_now);
                    check_field("impact_kind", want.impact_kind, result.impact_kind);
                    check_field("flag_value", want.flag_value, result.flag_value);
                    check_field("stab_total", want.stab_total, result.stab_total);
                    check_field("rotation_total", want.rotation_total, result.rotation_total);
                    check_field("accel_magnitude", want.accel_magnitude,
                                result.accel_magnitude);
                    check_field("peak_axis", want.peak_axis, result.peak_axis);
                    check_field("rate_magnitude", want.rate_magnitude, result.rate_magnitude);
                    check_field("rate_drop", want.rate_drop, result.rate_drop);
                end
            end
        end
    end

    // Driver: present pending items, holding each until accepted, with random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (items_taken != drv_seen)
            begin
                drv_seen = items_taken;
                holding = 1'b0;
                drv_gap = calm ? 0 : $urandom_range(0, 5);
            end
            if (!holding)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (pending_items.size() > 0)
                begin
                    drv_item = pending_items.pop_front();
                    holding = 1'b1;
                end
            end
            sample_valid <= holding;
            if (holding)
                sample <= drv_item;
        end
    end

    // Receiver: stall for a random number of cycles after each result transaction.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (results_taken != rcv_seen)
            begin
                rcv_seen = results_taken;
                rcv_stall = calm ? 0 : $urandom_range(0, 5);
            end
            if (rcv_stall > 0)
            begin
                rcv_stall--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic push_sample(input logic [31:0] t,
                               input logic [15:0] ax, ay, az, rx, ry, rz);
        sample_t s;
        s = '0;
        s.op = OP_SAMPLE;
        s.time_ms = t;
        s.accel_x = ax;
        s.accel_y = ay;
        s.accel_z = az;
        s.rate_x = rx;
        s.rate_y = ry;
        s.rate_z = rz;
        pending_items.push_back(s);
    endtask

    // A query carries random sample fields that the block must ignore.
    task automatic push_query();
        sample_t s;
        s = sample_t'({1'b0, $urandom(), $urandom(), $urandom(), $urandom()});
        s.op = OP_QUERY;
        pending_items.push_back(s);
    endtask

    // Axis value: mostly near the thresholds, sometimes the extremes or anything.
    function automatic logic [15:0] rand_axis(input int spread);
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2, 3: return 16'(int'($urandom_range(0, 2 * spread)) - spread);
            4, 5: return 16'(int'($urandom_range(0, 6 * spread)) - 3 * spread);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: ;
                1, 2, 3, 4, 5: clock_ms = clock_ms + $urandom_range(1, 700);
                6, 7: clock_ms = clock_ms + $urandom_range(1, 1500);
                8: clock_ms = clock_ms + $urandom();
                default: clock_ms = $urandom();
            endcase
            if ($urandom_range(0, 5) == 0)
                push_query();
            else
                push_sample(clock_ms, rand_axis(1800), rand_axis(1800), rand_axis(1800),
                            rand_axis(400), rand_axis(400), rand_axis(400));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Settings near the default thresholds; junk may fill the unused upper bits.
    task automatic write_random_limits(input bit junk);
        logic [15:0] top;
        top = junk ? 16'($urandom()) : 16'd0;
        write_reg(CFG_ACCEL_LIMIT, {top, 16'($urandom_range(1500, 5000))});
        write_reg(CFG_AXIS_LIMIT, {top, 16'($urandom_range(1000, 3000))});
        write_reg(CFG_DROP_LIMIT, {top, 16'($urandom_range(50, 600))});
        write_reg(CFG_CLASS_LIMIT, {top, 16'($urandom_range(100, 900))});
        write_reg(CFG_COOLDOWN, $urandom_range(0, 1200));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || holding || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Stimulus: directed cases at reset settings, then random phases between writes.
    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Query with nothing pending, then the cooldown edge measured from time zero.
        push_query();
        push_sample(32'd500, 16'd2000, 16'd2000, 16'd2000, 16'd600, 16'd0, 16'd0);
        // Magnitude just under, then just over its limit; the second is a rotation.
        push_sample(32'd501, 16'd1732, 16'd1732, 16'd1732, 16'd600, 16'd0, 16'd0);
        push_sample(32'd502, 16'd1733, 16'd1733, 16'd1733, 16'd500, 16'd0, 16'd0);
        // Read and clear the flag twice.
        push_query();
        push_query();
        // Single axis over its limit but inside the cooldown, then exactly at the limit.
        push_sample(32'd1002, -16'sd2501, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        push_sample(32'd1003, 16'd2500, 16'd0, 16'd0, 16'd301, 16'd0, 16'd0);
        // Drop just over its limit triggers a stab.
        push_sample(32'd1004, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        // Extreme axis values.
        push_sample(32'd2000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_sample(32'd3000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_sample(32'd4000, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'h8000, 16'h7FFF);
        // Drop exactly at the limit, then one above it.
        push_sample(32'd5000, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd0);
        push_sample(32'd6000, 16'd0, 16'd0, 16'd0, 16'd700, 16'd0, 16'd0);
        push_sample(32'd7000, 16'd0, 16'd0, 16'd0, 16'd399, 16'd0, 16'd0);
        // Rising rotation gives no drop.
        push_sample(32'd8000, 16'd10, 16'hFFF6, 16'd5, 16'd800, 16'd0, 16'd0);
        // Timestamp wrap across zero.
        push_sample(32'hFFFF_FFFF, 16'd3000, 16'd3000, 16'd0, 16'd0, 16'd0, 16'd0);
        push_sample(32'h0000_0100, 16'd3000, 16'd3000, 16'd0, 16'd0, 16'd0, 16'd0);
        push_sample(32'h0000_01F4, 16'd3000, 16'd3000, 16'd0, 16'd0, 16'd0, 16'd0);
        push_query();
        clock_ms = 32'h0000_01F4;
        wait_drained();

        // All limits and the cooldown at zero.
        write_reg(CFG_ACCEL_LIMIT, '0);
        write_reg(CFG_AXIS_LIMIT, '0);
        write_reg(CFG_DROP_LIMIT, '0);
        write_reg(CFG_CLASS_LIMIT, '0);
        write_reg(CFG_COOLDOWN, '0);
        push_random(60);
        wait_drained();

        // All limits and the cooldown at their maximum.
        write_reg(CFG_ACCEL_LIMIT, 32'h0000_FFFF);
        write_reg(CFG_AXIS_LIMIT, 32'h0000_FFFF);
        write_reg(CFG_DROP_LIMIT, 32'h0000_FFFF);
        write_reg(CFG_CLASS_LIMIT, 32'h0000_FFFF);
        write_reg(CFG_COOLDOWN, 32'hFFFF_FFFF);
        push_random(50);
        wait_drained();

        // Mid-range settings with no idling on either side.
        write_random_limits(1'b0);
        calm = 1'b1;
        push_random(100);
        wait_drained();
        calm = 1'b0;

        // Junk in the upper data bits and writes to unused indexes.
        write_random_limits(1'b1);
        for (int i = int'(CFG_COOLDOWN) + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), $urandom());
        push_random(120);
        wait_drained();

        write_random_limits(1'b0);
        push_random(120);
        wait_drained();

        repeat (60) @(negedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("motion_impact_detector_tb: clean");
        else
            $display("motion_impact_detector_tb: errors");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("motion_impact_detector_tb: errors");
        $finish;
    end

endmodule

FILE: motion_impact_detector.f
rtl/core/mid_pkg.sv
rtl/core/motion_impact_detector.sv
dv/motion_impact_detector_tb.sv
